>>> hdl/fsrm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsrm_pkg
// Shared types and constants of the sliding-window frame-rate meter.
// ----------------------------------------------------------------------------
package fsrm_pkg;

  // Field widths
  localparam int RATE_W   = 24;
  localparam int FRAMES_W = 9;
  localparam int WIN_W    = 24;
  localparam int THR_W    = 8;
  localparam int OUT_W    = 40;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_US        = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CHANGE_THRESHOLD = 1'b1;

  // Reset values of the registers
  localparam logic [WIN_W-1:0] WINDOW_US_RST        = 24'd1000000;
  localparam logic [THR_W-1:0] CHANGE_THRESHOLD_RST = 8'd2;

  // Input kinds
  localparam logic OP_FRAME = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  // Rate arithmetic: one microsecond in Q.8 per second, the zero-span cap
  localparam int                US_Q8_W     = 28;
  localparam logic [US_Q8_W-1:0] US_Q8      = 28'd256000000;
  localparam logic [RATE_W-1:0] RATE_CAP_Q8 = 24'd256000;
  localparam logic [RATE_W-1:0] RATE_MAX    = 24'hFFFFFF;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;        // latch time stamp, window limit
    logic frame_wr;    // store the stamp in the ring
    logic rd_oldest;   // read the oldest stamp
    logic evict;       // drop the oldest stamp
    logic rd_last;     // latch the first stamp, read the newest one
    logic span_load;   // form span and dividend, start the divider
    logic div_step;    // one quotient bit
    logic finish;      // update stored rate and load the result word
  } fsrm_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic count_zero;
    logic count_lt2;
    logic evict_en;
    logic too_old;
    logic div_last;
  } fsrm_stat_t;

endpackage

>>> hdl/sliding_window_frame_rate_meter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_frame_rate_meter
// Frame-rate meter over a sliding window of frame time stamps.
// ----------------------------------------------------------------------------
// A frame word (tuser 0) stores its time stamp in a RING_DEPTH-entry ring. A
// tick word (tuser 1) drops stamps older than the window, computes
// (count-1)*256e6/span as Q.8 fps and emits one result word. The eviction
// walk reads the ring one stamp at a time through its single read port, and
// the divider yields one quotient bit a cycle over N = clog2(RING_DEPTH+1) +
// 28 bits (37 at the default depth). One word is in work at a time; a new
// word is taken while the previous result still waits. The ring needs no
// clearing pass after reset.
module sliding_window_frame_rate_meter
  import fsrm_pkg::*;
#(
  parameter int RING_DEPTH = 256,
  parameter int TIME_BITS  = 40,
  localparam int IN_W      = ((TIME_BITS + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_W-1:0]       s_tdata,   // time_us
  input  logic                  s_tuser,   // opcode
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_W-1:0]      m_tdata,   // fps_q8, frames_in_window
  output logic                  m_tuser,   // changed
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  fsrm_cmd_t             cmd;
  fsrm_stat_t            stat;
  logic [RATE_W-1:0]     fps_q8;
  logic                  changed;
  logic [FRAMES_W-1:0]   frames_in_window;

  fsrm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  fsrm_dp #(
    .RING_DEPTH (RING_DEPTH),
    .TIME_BITS  (TIME_BITS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .time_us          (s_tdata[TIME_BITS-1:0]),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .fps_q8           (fps_q8),
    .changed          (changed),
    .frames_in_window (frames_in_window)
  );

  // Pack the result word
  assign m_tdata = {(OUT_W - RATE_W - FRAMES_W)'(0), frames_in_window, fps_q8};
  assign m_tuser = changed;

  // A result is loaded only into a free or draining output register
  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (!m_tvalid || m_tready))
    else $error("result word overwritten before it was taken");

  // Nothing but the load runs while the input side is open
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !(cmd.frame_wr || cmd.evict || cmd.div_step || cmd.finish))
    else $error("datapath busy while accepting a word");

  // Eviction never runs on an empty ring
  a_evict_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.evict |-> (!stat.count_zero && stat.evict_en))
    else $error("eviction on an empty ring or before the window");

  // A result word appears only after a finish
  a_valid_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(cmd.finish))
    else $error("result valid without a finished tick");

endmodule

>>> hdl/fsrm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsrm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fsrm_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 256,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/fsrm_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsrm_dp
// Datapath: stamp ring, ring pointers, window compare, bit-serial divider,
// stored rate and the result word register.
// ----------------------------------------------------------------------------
module fsrm_dp
  import fsrm_pkg::*;
#(
  parameter int RING_DEPTH = 256,
  parameter int TIME_BITS  = 40
) (
  input  logic                  clk,
  input  logic                  rst,
  input  fsrm_cmd_t             cmd,
  output fsrm_stat_t            stat,
  input  logic [TIME_BITS-1:0]  time_us,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic [RATE_W-1:0]     fps_q8,
  output logic                  changed,
  output logic [FRAMES_W-1:0]   frames_in_window
);

  localparam int AW    = $clog2(RING_DEPTH);
  localparam int CNT_W = $clog2(RING_DEPTH + 1);
  localparam int NUM_W = CNT_W + US_Q8_W;
  localparam int DC_W  = $clog2(NUM_W);

  localparam logic [AW:0]      DEPTH_EXT = (AW + 1)'(RING_DEPTH);
  localparam logic [AW-1:0]    LAST_IDX  = AW'(RING_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(RING_DEPTH);
  localparam logic [DC_W-1:0]  DIV_LAST  = DC_W'(NUM_W - 1);

  // Configuration registers
  logic [WIN_W-1:0] window_us;
  logic [THR_W-1:0] change_threshold;

  // Ring control and stored rate
  logic [AW-1:0]     oldest_index;
  logic [CNT_W-1:0]  stamp_count;
  logic [RATE_W-1:0] current_rate;

  // Per-item working registers
  logic [TIME_BITS-1:0] now;
  logic [TIME_BITS-1:0] limit;
  logic                 evict_en;
  logic [TIME_BITS-1:0] first_stamp;
  logic [TIME_BITS-1:0] span;
  logic                 span_le;
  logic [NUM_W-1:0]     quo;
  logic [TIME_BITS-1:0] rem;
  logic [DC_W-1:0]      div_cnt;

  // Ring port signals
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [AW-1:0]        ram_raddr;
  logic [TIME_BITS-1:0] ram_rdata;
  logic [AW:0]          wr_sum;
  logic [AW:0]          last_sum;
  logic [AW-1:0]        wr_pos;
  logic [AW-1:0]        last_pos;
  logic [AW-1:0]        oldest_next;
  logic [CNT_W-1:0]     count_m1;

  // Divider step and rate selection
  logic [TIME_BITS:0]   rem_sh;
  logic                 rem_ge;
  logic [NUM_W-1:0]     prod;
  logic [RATE_W-1:0]    div_rate;
  logic [RATE_W-1:0]    new_rate;
  logic [RATE_W-1:0]    diff;
  logic                 upd;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      window_us        <= WINDOW_US_RST;
      change_threshold <= CHANGE_THRESHOLD_RST;
    end else if (cfg_we) begin
      if (cfg_index == REG_WINDOW_US) begin
        window_us <= cfg_data[WIN_W-1:0];
      end
      if (cfg_index == REG_CHANGE_THRESHOLD) begin
        change_threshold <= cfg_data[THR_W-1:0];
      end
    end
  end

  // Ring positions, wrapped with one compare and subtract
  assign count_m1 = stamp_count - CNT_W'(1);
  assign wr_sum   = (AW + 1)'(oldest_index) + (AW + 1)'(stamp_count);
  assign last_sum = (AW + 1)'(oldest_index) + (AW + 1)'(count_m1);

  always_comb begin
    wr_pos      = (wr_sum >= DEPTH_EXT) ? AW'(wr_sum - DEPTH_EXT) : wr_sum[AW-1:0];
    last_pos    = (last_sum >= DEPTH_EXT) ? AW'(last_sum - DEPTH_EXT) : last_sum[AW-1:0];
    oldest_next = (oldest_index == LAST_IDX) ? '0 : oldest_index + AW'(1);
  end

  assign ram_we    = cmd.frame_wr;
  assign ram_waddr = wr_pos;
  assign ram_raddr = cmd.rd_last ? last_pos : oldest_index;

  fsrm_ram #(
    .WIDTH (TIME_BITS),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (now),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Advance pointers on frame store and on eviction
  always_ff @(posedge clk) begin
    if (rst) begin
      oldest_index <= '0;
      stamp_count  <= '0;
    end else if (cmd.frame_wr) begin
      if (stamp_count == FULL_CNT) begin
        oldest_index <= oldest_next;
      end else begin
        stamp_count <= stamp_count + CNT_W'(1);
      end
    end else if (cmd.evict) begin
      oldest_index <= oldest_next;
      stamp_count  <= count_m1;
    end
  end

  // Latch the item time and the eviction limit
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      now      <= time_us;
      limit    <= time_us - TIME_BITS'(window_us);
      evict_en <= time_us >= TIME_BITS'(window_us);
    end
    if (cmd.rd_last) begin
      first_stamp <= ram_rdata;
    end
  end

  // Restoring divider, one quotient bit a cycle
  assign rem_sh = {rem, quo[NUM_W-1]};
  assign rem_ge = rem_sh >= {1'b0, span};
  assign prod   = NUM_W'(count_m1) * NUM_W'(US_Q8);

  always_ff @(posedge clk) begin
    if (cmd.span_load) begin
      span    <= ram_rdata - first_stamp;
      span_le <= ram_rdata <= first_stamp;
      quo     <= prod;
      rem     <= '0;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      rem     <= rem_ge ? TIME_BITS'(rem_sh - {1'b0, span}) : rem_sh[TIME_BITS-1:0];
      quo     <= {quo[NUM_W-2:0], rem_ge};
      div_cnt <= div_cnt + DC_W'(1);
    end
  end

  // Pick the new rate and decide whether the stored rate follows it
  always_comb begin
    div_rate = (|quo[NUM_W-1:RATE_W]) ? RATE_MAX : quo[RATE_W-1:0];
    if (stat.count_lt2) begin
      new_rate = '0;
    end else if (span_le) begin
      new_rate = RATE_CAP_Q8;
    end else begin
      new_rate = div_rate;
    end
    diff = (new_rate > current_rate) ? new_rate - current_rate : current_rate - new_rate;
    if (stat.count_lt2) begin
      upd = current_rate != '0;
    end else begin
      upd = diff > RATE_W'(change_threshold);
    end
  end

  // Stored rate and result word
  always_ff @(posedge clk) begin
    if (rst) begin
      current_rate <= '0;
    end else if (cmd.finish && upd) begin
      current_rate <= new_rate;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      fps_q8           <= upd ? new_rate : current_rate;
      changed          <= upd;
      frames_in_window <= FRAMES_W'(stamp_count);
    end
  end

  // Status
  always_comb begin
    stat.count_zero = stamp_count == '0;
    stat.count_lt2  = stamp_count < CNT_W'(2);
    stat.evict_en   = evict_en;
    stat.too_old    = ram_rdata < limit;
    stat.div_last   = div_cnt == DIV_LAST;
  end

endmodule

>>> hdl/fsrm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsrm_ctrl
// Controller: sequences frame stores, the eviction walk, the rate division
// and the hand-off of each tick's result word.
// ----------------------------------------------------------------------------
module fsrm_ctrl
  import fsrm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic       s_tuser,
  output logic       m_tvalid,
  input  logic       m_tready,
  input  fsrm_stat_t stat,
  output fsrm_cmd_t  cmd
);

  typedef enum logic [9:0] {
    ST_IDLE     = 10'b0000000001,
    ST_FRAME_WR = 10'b0000000010,
    ST_EV_RD    = 10'b0000000100,
    ST_EV_CHK   = 10'b0000001000,
    ST_RATE_SEL = 10'b0000010000,
    ST_LAST_RD  = 10'b0000100000,
    ST_SPAN     = 10'b0001000000,
    ST_DIV      = 10'b0010000000,
    ST_FINISH   = 10'b0100000000,
    ST_SPARE    = 10'b1000000000
  } fsrm_state_t;

  fsrm_state_t state;
  fsrm_state_t state_next;
  logic        out_free;

  assign s_tready = state == ST_IDLE;
  assign out_free = !m_tvalid || m_tready;

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = (s_tuser == OP_FRAME) ? ST_FRAME_WR : ST_EV_RD;
        end
      end
      ST_FRAME_WR: begin
        cmd.frame_wr = 1'b1;
        state_next   = ST_IDLE;
      end
      ST_EV_RD: begin
        if (stat.count_zero || !stat.evict_en) begin
          state_next = ST_RATE_SEL;
        end else begin
          cmd.rd_oldest = 1'b1;
          state_next    = ST_EV_CHK;
        end
      end
      ST_EV_CHK: begin
        if (stat.too_old) begin
          cmd.evict  = 1'b1;
          state_next = ST_EV_RD;
        end else begin
          state_next = ST_RATE_SEL;
        end
      end
      ST_RATE_SEL: begin
        if (stat.count_lt2) begin
          state_next = ST_FINISH;
        end else begin
          cmd.rd_oldest = 1'b1;
          state_next    = ST_LAST_RD;
        end
      end
      ST_LAST_RD: begin
        cmd.rd_last = 1'b1;
        state_next  = ST_SPAN;
      end
      ST_SPAN: begin
        cmd.span_load = 1'b1;
        state_next    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Result word valid: set on finish, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

endmodule
